// File: hw/rtl/fft_bin_magnitude_detect_macros.svh
// Assertion macros used by the checker of this block.
`ifndef FFT_BIN_MAGNITUDE_DETECT_MACROS_SVH
`define FFT_BIN_MAGNITUDE_DETECT_MACROS_SVH

// Labelled clocked assertion, quiet while reset is held.
`define FBMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Labelled clocked implication, quiet while reset is held.
`define FBMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) else $error(msg);

`endif

// File: hw/rtl/fbmd_pkg.sv
package fbmd_pkg;

  // Field widths
  localparam int unsigned CPLX_W  = 16;
  localparam int unsigned BIN_W   = 7;
  localparam int unsigned MAG_W   = 17;
  localparam int unsigned FREQ_W  = 31;
  localparam int unsigned BINW_W  = 24;
  localparam int unsigned THR_W   = 17;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned SQR_W   = 31;
  localparam int unsigned SUM_W   = 32;

  // Square root datapath: 36-bit radicand, 18 root bits, two bits per stage
  localparam int unsigned RAD_W       = 36;
  localparam int unsigned ROOT_W      = 18;
  localparam int unsigned REM_W       = 21;
  localparam int unsigned SQRT_STAGES = ROOT_W / 2;

  // Accept edge to the edge that takes the result
  localparam int unsigned LATENCY = SQRT_STAGES + 3;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_BIN_WIDTH = 1'b1
  } reg_idx_e;

  localparam logic [BINW_W-1:0] BIN_WIDTH_RST = BINW_W'(20000);

  // Fields that ride alongside the magnitude computation
  typedef struct packed {
    logic [BIN_W-1:0]  bin;
    logic [FREQ_W-1:0] freq;
  } side_t;

  // Digit-by-digit square root working set
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // One root bit: bring in two radicand bits, trial subtract
  function automatic sqrt_t sqrt_step(sqrt_t x);
    sqrt_t            y;
    logic [REM_W-1:0] rem_n;
    logic [REM_W-1:0] trial;
    rem_n = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
    trial = {1'b0, x.root, 2'b01};
    y.rad = {x.rad[RAD_W-3:0], 2'b00};
    if (rem_n >= trial) begin
      y.rem  = rem_n - trial;
      y.root = {x.root[ROOT_W-2:0], 1'b1};
    end else begin
      y.rem  = rem_n;
      y.root = {x.root[ROOT_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

// File: hw/rtl/fbmd_square.sv
module fbmd_square (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [fbmd_pkg::CPLX_W-1:0] real_part_i,
  input  logic signed [fbmd_pkg::CPLX_W-1:0] imag_part_i,
  input  fbmd_pkg::side_t                  side_i,
  output logic                             valid_o,
  output logic [fbmd_pkg::SUM_W-1:0]       sum_o,
  output fbmd_pkg::side_t                  side_o
);

  logic signed [2*fbmd_pkg::CPLX_W-1:0] re_prod;
  logic signed [2*fbmd_pkg::CPLX_W-1:0] im_prod;

  logic                          vld1_q;
  logic [fbmd_pkg::SQR_W-1:0]    re_sq_q;
  logic [fbmd_pkg::SQR_W-1:0]    im_sq_q;
  fbmd_pkg::side_t               side1_q;

  logic                          vld2_q;
  logic [fbmd_pkg::SUM_W-1:0]    sum_q;
  fbmd_pkg::side_t               side2_q;

  // Square both components; each square is below 2^31
  assign re_prod = real_part_i * real_part_i;
  assign im_prod = imag_part_i * imag_part_i;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  // Hold squares, then their sum
  always_ff @(posedge clk_i) begin
    re_sq_q <= re_prod[fbmd_pkg::SQR_W-1:0];
    im_sq_q <= im_prod[fbmd_pkg::SQR_W-1:0];
    side1_q <= side_i;
    sum_q   <= fbmd_pkg::SUM_W'(re_sq_q) + fbmd_pkg::SUM_W'(im_sq_q);
    side2_q <= side1_q;
  end

  assign valid_o = vld2_q;
  assign sum_o   = sum_q;
  assign side_o  = side2_q;

endmodule

// File: hw/rtl/fbmd_sqrt_pipe.sv
module fbmd_sqrt_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [fbmd_pkg::SUM_W-1:0]    sum_i,
  input  fbmd_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [fbmd_pkg::MAG_W-1:0]    root_o,
  output fbmd_pkg::side_t               side_o
);

  localparam int unsigned NS = fbmd_pkg::SQRT_STAGES;

  logic            vld_q  [NS];
  fbmd_pkg::sqrt_t st_q   [NS];
  fbmd_pkg::side_t side_q [NS];
  fbmd_pkg::sqrt_t init;

  // Radicand is four times the sum of squares
  assign init.rad  = {2'b00, sum_i, 2'b00};
  assign init.rem  = '0;
  assign init.root = '0;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    fbmd_pkg::sqrt_t st_in;
    fbmd_pkg::sqrt_t st_mid;
    fbmd_pkg::sqrt_t st_out;
    logic            vld_in;
    fbmd_pkg::side_t side_in;

    if (s == 0) begin : g_first
      assign st_in   = init;
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign st_in   = st_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Resolve two root bits per stage
    assign st_mid = fbmd_pkg::sqrt_step(st_in);
    assign st_out = fbmd_pkg::sqrt_step(st_mid);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s]   <= st_out;
      side_q[s] <= side_in;
    end
  end

  // Root never exceeds 92681, so the top bit is always clear
  assign valid_o = vld_q[NS-1];
  assign root_o  = st_q[NS-1].root[fbmd_pkg::MAG_W-1:0];
  assign side_o  = side_q[NS-1];

endmodule

// File: hw/rtl/fft_bin_magnitude_detect.sv
// FFT bin magnitude detector.
// Input channel: present real_part_i, imag_part_i and bin_number_i with start
// high; the item is taken at that clock edge. busy is always low, so a new
// bin may be presented in every cycle and the block sustains one item a cycle.
// Result channel: result_valid_o is high for exactly one cycle carrying
// magnitude_o (floor of twice |z|, halved for bin zero), above_threshold_o,
// frequency_o (bin number times bin width, Q8 Hz) and bin_echo_o. The
// receiver cannot hold results off; results leave in input order.
// From the accepting edge to the edge that takes the result, two stages square
// and sum, nine stages of the pipelined square root resolve two root bits each,
// and one stage halves, compares and registers.
// Configuration: write cfg_wdata_i to register cfg_idx_i (0 threshold,
// 1 bin width) with cfg_we_i high, only while no items are in flight.
// Reset clears every valid bit, sets the threshold to 0 and the bin width to
// 20000 (78.125 Hz); items in flight at reset are dropped.
module fft_bin_magnitude_detect (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [fbmd_pkg::CPLX_W-1:0] real_part_i,
  input  logic signed [fbmd_pkg::CPLX_W-1:0] imag_part_i,
  input  logic [fbmd_pkg::BIN_W-1:0]        bin_number_i,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [fbmd_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                              result_valid_o,
  output logic [fbmd_pkg::MAG_W-1:0]        magnitude_o,
  output logic                              above_threshold_o,
  output logic [fbmd_pkg::FREQ_W-1:0]       frequency_o,
  output logic [fbmd_pkg::BIN_W-1:0]        bin_echo_o
);

  logic [fbmd_pkg::THR_W-1:0]  thr_q;
  logic [fbmd_pkg::BINW_W-1:0] binw_q;

  logic                        accept;
  fbmd_pkg::side_t             side_in;
  logic                        sq_vld;
  logic [fbmd_pkg::SUM_W-1:0]  sq_sum;
  fbmd_pkg::side_t             sq_side;
  logic                        rt_vld;
  logic [fbmd_pkg::MAG_W-1:0]  rt_root;
  fbmd_pkg::side_t             rt_side;

  logic [fbmd_pkg::MAG_W-1:0]  mag_d;
  logic                        vld_q;
  logic [fbmd_pkg::MAG_W-1:0]  mag_q;
  logic                        above_q;
  logic [fbmd_pkg::FREQ_W-1:0] freq_q;
  logic [fbmd_pkg::BIN_W-1:0]  bin_q;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      binw_q <= fbmd_pkg::BIN_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (fbmd_pkg::reg_idx_e'(cfg_idx_i))
        fbmd_pkg::REG_THRESHOLD: thr_q  <= cfg_wdata_i[fbmd_pkg::THR_W-1:0];
        fbmd_pkg::REG_BIN_WIDTH: binw_q <= cfg_wdata_i[fbmd_pkg::BINW_W-1:0];
        default: ;
      endcase
    end
  end

  // An item is taken whenever start is high; busy is tied low
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Frequency is a 7 by 24 product, it fits 31 bits exactly
  assign side_in.bin  = bin_number_i;
  assign side_in.freq = fbmd_pkg::FREQ_W'(bin_number_i) * fbmd_pkg::FREQ_W'(binw_q);

  fbmd_square u_square (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .side_i      (side_in),
    .valid_o     (sq_vld),
    .sum_o       (sq_sum),
    .side_o      (sq_side)
  );

  fbmd_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .sum_i   (sq_sum),
    .side_i  (sq_side),
    .valid_o (rt_vld),
    .root_o  (rt_root),
    .side_o  (rt_side)
  );

  // Halve the DC bin
  assign mag_d = (rt_side.bin == '0) ? (rt_root >> 1) : rt_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= rt_vld;
    end
  end

  // Register the result
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    above_q <= (mag_d >= thr_q);
    freq_q  <= rt_side.freq;
    bin_q   <= rt_side.bin;
  end

  assign result_valid_o    = vld_q;
  assign magnitude_o       = mag_q;
  assign above_threshold_o = above_q;
  assign frequency_o       = freq_q;
  assign bin_echo_o        = bin_q;

endmodule

// File: hw/rtl/fbmd_checker.sv
`include "fft_bin_magnitude_detect_macros.svh"

module fbmd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [fbmd_pkg::BIN_W-1:0]  bin_number_i,
  input logic                        result_valid_o,
  input logic [fbmd_pkg::MAG_W-1:0]  magnitude_o,
  input logic [fbmd_pkg::FREQ_W-1:0] frequency_o,
  input logic [fbmd_pkg::BIN_W-1:0]  bin_echo_o
);

  localparam int unsigned LAT = fbmd_pkg::LATENCY;
  localparam logic [fbmd_pkg::MAG_W-1:0] MAG_MAX    = fbmd_pkg::MAG_W'(92681);
  localparam logic [fbmd_pkg::MAG_W-1:0] MAG_DC_MAX = fbmd_pkg::MAG_W'(46340);

  logic accept;
  logic dc_res;

  assign accept = start && !busy;
  assign dc_res = result_valid_o && (bin_echo_o == '0);

  // Every accepted item leaves after the fixed latency, with its own bin
  `FBMD_ASSERT_IMP(a_result_follows, accept, ##LAT result_valid_o, "result missing")
  `FBMD_ASSERT_IMP(a_bin_seq, accept, ##LAT (bin_echo_o == $past(bin_number_i, LAT)), "bin order")

  // Magnitude stays in range, tighter for the halved DC bin
  `FBMD_ASSERT(a_mag_range, !result_valid_o || (magnitude_o <= MAG_MAX), "magnitude too large")
  `FBMD_ASSERT_IMP(a_dc_halved, dc_res, magnitude_o <= MAG_DC_MAX, "DC magnitude too large")
  `FBMD_ASSERT_IMP(a_dc_freq, dc_res, frequency_o == '0, "DC frequency not zero")

endmodule

bind fft_bin_magnitude_detect fbmd_checker u_fbmd_checker (.*);
